### src/tgc_pkg.sv
// Package for the touch gesture classifier: widths, reset values, event codes,
// register indexes and the structs passed between the submodules.
// No dependencies; every other file depends on it.
package tgc_pkg;

   localparam int NUM_ZONES_DEF = 4;
   localparam int ZONE_W        = 2;
   localparam int KIND_W        = 3;
   localparam int TIME_W        = 32;
   localparam int LIM_W         = 16;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   // Result queue sizing
   localparam int EVQ_DEPTH = 8;
   localparam int EVQ_PTR_W = 3;
   localparam int EVQ_CNT_W = 4;

   // Register reset values
   localparam logic [LIM_W-1:0] TAP_MAX_RST  = 16'd500;
   localparam logic [LIM_W-1:0] DTAP_WIN_RST = 16'd400;
   localparam logic [LIM_W-1:0] LONG_RST     = 16'd2000;

   typedef enum logic [KIND_W-1:0] {
      KIND_HOLD_START = 3'd0,
      KIND_HOLD_END   = 3'd1,
      KIND_LONG_PRESS = 3'd2,
      KIND_DOUBLE_TAP = 3'd3,
      KIND_TAP        = 3'd4
   } event_kind_type;

   typedef enum logic [1:0] {
      REG_PUSH_TO_TALK = 2'd0,
      REG_TAP_MAX      = 2'd1,
      REG_DTAP_WINDOW  = 2'd2,
      REG_LONG_PRESS   = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic             push_to_talk;
      logic [LIM_W-1:0] tap_limit;
      logic [LIM_W-1:0] dtap_window;
      logic [LIM_W-1:0] long_limit;
   } cfg_type;

   typedef struct packed {
      logic              active;
      logic [TIME_W-1:0] press_start;
      logic [TIME_W-1:0] last_tap;
      logic              pending;
   } zone_state_type;

   typedef struct packed {
      logic [ZONE_W-1:0] event_zone;
      event_kind_type    event_kind;
      logic [TIME_W-1:0] duration;
      logic              last_event;
   } evt_type;

   // Up to two events per request; when only one, it sits in first
   typedef struct packed {
      logic [1:0] num;
      evt_type    first;
      evt_type    second;
   } evt_push_type;

endpackage

### src/tgc_if.sv
// Valid/ready channel interfaces for requests (samples) and results (events).
// Depends on tgc_pkg.
interface tgc_req_if;
   logic                          valid;
   logic                          ready;
   logic [tgc_pkg::ZONE_W-1:0]    zone_index;
   logic                          touched;
   logic [tgc_pkg::TIME_W-1:0]    now_ms;

   modport source (output valid, zone_index, touched, now_ms, input ready);
   modport sink   (input valid, zone_index, touched, now_ms, output ready);
endinterface

interface tgc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tgc_pkg::ZONE_W-1:0]    event_zone;
   tgc_pkg::event_kind_type       event_kind;
   logic [tgc_pkg::TIME_W-1:0]    duration;
   logic                          last_event;

   modport source (output valid, event_zone, event_kind, duration, last_event, input ready);
   modport sink   (input valid, event_zone, event_kind, duration, last_event, output ready);
endinterface

### src/tgc_csr.sv
// APB-style register block holding the gesture limits and push-to-talk mode.
// Depends on tgc_pkg.
module tgc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tgc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tgc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output tgc_pkg::cfg_type                cfg
);
   import tgc_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_sel = csr_reg_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite && pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_PUSH_TO_TALK: cfg_in.push_to_talk = pwdata[0];
            REG_TAP_MAX:      cfg_in.tap_limit    = pwdata[LIM_W-1:0];
            REG_DTAP_WINDOW:  cfg_in.dtap_window  = pwdata[LIM_W-1:0];
            REG_LONG_PRESS:   cfg_in.long_limit   = pwdata[LIM_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.push_to_talk <= 1'b0;
         cfg_ff.tap_limit    <= TAP_MAX_RST;
         cfg_ff.dtap_window  <= DTAP_WIN_RST;
         cfg_ff.long_limit   <= LONG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         REG_PUSH_TO_TALK: prdata = CSR_DATA_W'(cfg_ff.push_to_talk);
         REG_TAP_MAX:      prdata = CSR_DATA_W'(cfg_ff.tap_limit);
         REG_DTAP_WINDOW:  prdata = CSR_DATA_W'(cfg_ff.dtap_window);
         REG_LONG_PRESS:   prdata = CSR_DATA_W'(cfg_ff.long_limit);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### src/tgc_core.sv
// Per-zone state memory and the read-modify-write pipeline that classifies
// touch edges into gesture events. Depends on tgc_pkg and tgc_if.
module tgc_core #(
   parameter int NUM_ZONES = tgc_pkg::NUM_ZONES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tgc_pkg::cfg_type               cfg,
   tgc_req_if.sink                        req_bus,
   input  logic [tgc_pkg::EVQ_CNT_W-1:0]  evq_free,
   output tgc_pkg::evt_push_type          evt_push
);
   import tgc_pkg::*;

   localparam int AW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;

   // state memory, reset value is all zero: entries without a valid bit read as zero
   zone_state_type        mem [NUM_ZONES];
   logic [NUM_ZONES-1:0]  vld_ff;
   zone_state_type        rd_data_ff;
   logic                  rd_vld_ff;

   // stage 1 request registers
   logic                  s1_vld_ff;
   logic                  s1_inrange_ff;
   logic [AW-1:0]         s1_addr_ff;
   logic [ZONE_W-1:0]     s1_zone_ff;
   logic                  s1_touched_ff;
   logic [TIME_W-1:0]     s1_now_ff;

   // last write, for forwarding into the next request
   logic                  fwd_vld_ff;
   logic [AW-1:0]         fwd_addr_ff;
   zone_state_type        fwd_data_ff;

   logic                  accept;
   logic                  in_range;
   logic [AW-1:0]         rd_addr;
   logic [EVQ_CNT_W:0]    need;
   logic                  wr_en;

   zone_state_type        st;
   zone_state_type        nst;
   logic                  ptt_zone;
   logic [TIME_W-1:0]     dur;
   logic [TIME_W-1:0]     gap;
   logic [TIME_W-1:0]     flush_gap;
   logic                  set_tap;
   logic                  ev1_vld;
   event_kind_type        ev1_kind;
   logic [TIME_W-1:0]     ev1_dur;
   logic                  ev2_vld;
   evt_type               ev1;
   evt_type               ev2;

   // room for this request's events plus those of the one in stage 1
   assign need  = (EVQ_CNT_W+1)'(2) + (s1_vld_ff ? (EVQ_CNT_W+1)'(2) : '0);
   assign req_bus.ready = ({1'b0, evq_free} >= need);
   assign accept   = req_bus.valid && req_bus.ready;
   assign in_range = (32'(req_bus.zone_index) < 32'(NUM_ZONES));
   assign rd_addr  = AW'(req_bus.zone_index);

   // synchronous read of the zone entry
   always_ff @(posedge clock) begin
      if (accept && in_range) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
      if (wr_en) begin
         mem[s1_addr_ff] <= nst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= accept;
         fwd_vld_ff <= wr_en;
         if (wr_en) begin
            vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_inrange_ff <= in_range;
         s1_addr_ff    <= rd_addr;
         s1_zone_ff    <= req_bus.zone_index;
         s1_touched_ff <= req_bus.touched;
         s1_now_ff     <= req_bus.now_ms;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= nst;
      end
   end

   // pick up the previous write when it hit the same zone
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == s1_addr_ff)) begin
         st = fwd_data_ff;
      end else if (rd_vld_ff) begin
         st = rd_data_ff;
      end else begin
         st = '0;
      end
   end

   assign wr_en     = s1_vld_ff && s1_inrange_ff;
   assign ptt_zone  = cfg.push_to_talk && (s1_zone_ff == '0);
   assign dur       = s1_now_ff - st.press_start;
   assign gap       = s1_now_ff - st.last_tap;

   // edge handling and release classification
   always_comb begin
      nst      = st;
      ev1_vld  = 1'b0;
      ev1_kind = KIND_HOLD_START;
      ev1_dur  = '0;
      set_tap  = 1'b0;
      if (s1_touched_ff && !st.active) begin
         nst.active      = 1'b1;
         nst.press_start = s1_now_ff;
         ev1_vld         = ptt_zone;
      end else if (!s1_touched_ff && st.active) begin
         nst.active = 1'b0;
         if (ptt_zone) begin
            ev1_vld  = 1'b1;
            ev1_kind = KIND_HOLD_END;
            ev1_dur  = dur;
         end else if (dur >= TIME_W'(cfg.long_limit)) begin
            ev1_vld     = 1'b1;
            ev1_kind    = KIND_LONG_PRESS;
            ev1_dur     = dur;
            nst.pending = 1'b0;
         end else if (dur < TIME_W'(cfg.tap_limit)) begin
            if (st.pending && (gap < TIME_W'(cfg.dtap_window))) begin
               ev1_vld     = 1'b1;
               ev1_kind    = KIND_DOUBLE_TAP;
               ev1_dur     = dur;
               nst.pending = 1'b0;
            end else begin
               nst.pending  = 1'b1;
               nst.last_tap = s1_now_ff;
               set_tap      = 1'b1;
            end
         end
      end
      // pending tap flush; a freshly recorded tap has zero gap
      flush_gap = set_tap ? '0 : gap;
      ev2_vld   = !nst.active && nst.pending &&
                  (flush_gap >= TIME_W'(cfg.dtap_window));
      if (ev2_vld) begin
         nst.pending = 1'b0;
      end
   end

   // event packing toward the result queue
   always_comb begin
      ev1.event_zone = s1_zone_ff;
      ev1.event_kind = ev1_kind;
      ev1.duration   = ev1_dur;
      ev1.last_event = !ev2_vld;
      ev2.event_zone = s1_zone_ff;
      ev2.event_kind = KIND_TAP;
      ev2.duration   = '0;
      ev2.last_event = 1'b1;
      evt_push.first  = ev1_vld ? ev1 : ev2;
      evt_push.second = ev2;
      if (!wr_en) begin
         evt_push.num = 2'd0;
      end else begin
         evt_push.num = 2'(ev1_vld) + 2'(ev2_vld);
      end
   end

endmodule

### src/tgc_evq.sv
// Result queue: takes up to two events per cycle, hands out one per cycle
// while rsp_bus.ready is high. Depends on tgc_pkg and tgc_if.
module tgc_evq (
   input  logic                           clock,
   input  logic                           reset,
   input  tgc_pkg::evt_push_type          evt_push,
   output logic [tgc_pkg::EVQ_CNT_W-1:0]  evq_free,
   tgc_rsp_if.source                      rsp_bus
);
   import tgc_pkg::*;

   evt_type                q_ff [EVQ_DEPTH];
   logic [EVQ_PTR_W-1:0]   wr_ptr_ff;
   logic [EVQ_PTR_W-1:0]   wr_ptr_in;
   logic [EVQ_PTR_W-1:0]   rd_ptr_ff;
   logic [EVQ_PTR_W-1:0]   rd_ptr_in;
   logic [EVQ_CNT_W-1:0]   cnt_ff;
   logic [EVQ_CNT_W-1:0]   cnt_in;
   logic                   pop;
   evt_type                head;

   assign pop = rsp_bus.valid && rsp_bus.ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + EVQ_PTR_W'(evt_push.num);
      rd_ptr_in = rd_ptr_ff + EVQ_PTR_W'(pop);
      cnt_in    = cnt_ff + EVQ_CNT_W'(evt_push.num) - EVQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (evt_push.num != 2'd0) begin
         q_ff[wr_ptr_ff] <= evt_push.first;
      end
      if (evt_push.num == 2'd2) begin
         q_ff[wr_ptr_ff + EVQ_PTR_W'(1)] <= evt_push.second;
      end
   end

   assign evq_free = EVQ_CNT_W'(EVQ_DEPTH) - cnt_ff;
   assign head     = q_ff[rd_ptr_ff];

   assign rsp_bus.valid      = (cnt_ff != '0);
   assign rsp_bus.event_zone = head.event_zone;
   assign rsp_bus.event_kind = head.event_kind;
   assign rsp_bus.duration   = head.duration;
   assign rsp_bus.last_event = head.last_event;

endmodule

### src/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: register block, zone pipeline
// and result queue. Depends on tgc_pkg, tgc_if, tgc_csr, tgc_core, tgc_evq.
//
// Usage:
//  - req_bus takes one sample per request: zone_index, touched, now_ms.
//  - rsp_bus gives gesture events: event_zone, event_kind, duration and
//    last_event, which marks the final event caused by one sample. A sample
//    yields zero, one or two events; samples whose zone_index is NUM_ZONES
//    or more yield none and change nothing.
//  - The APB port (psel ... pready) holds push_to_talk at 0x0, the tap limit
//    at 0x4, the double-tap window at 0x8 and the long-press limit at 0xC.
//    Write it only while no sample is in flight.
//  - Pipeline: a sample accepted at a clock edge reads its zone entry into
//    the stage 1 registers; from there its events are written into the
//    result queue, from which the first one can then be taken.
//  - Throughput: one sample per cycle while req_bus.ready is high, one
//    event out per cycle while rsp_bus.ready is high. A zone entry written
//    back is forwarded to a directly following sample of the same zone.
//  - Reset clears all zone state, the registers (0, 500, 400, 2000) and the
//    8-entry result queue. req_bus.ready is low while the queue lacks two
//    free entries per sample in flight and new.
module touch_gesture_classifier #(
   parameter int NUM_ZONES = tgc_pkg::NUM_ZONES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tgc_req_if.sink                         req_bus,
   tgc_rsp_if.source                       rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tgc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tgc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import tgc_pkg::*;

   cfg_type                cfg;
   evt_push_type           evt_push;
   logic [EVQ_CNT_W-1:0]   evq_free;

   tgc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tgc_core #(
      .NUM_ZONES (NUM_ZONES)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_bus  (req_bus),
      .evq_free (evq_free),
      .evt_push (evt_push)
   );

   tgc_evq u_evq (
      .clock    (clock),
      .reset    (reset),
      .evt_push (evt_push),
      .evq_free (evq_free),
      .rsp_bus  (rsp_bus)
   );

endmodule
